@@ rtl/core/afp_pkg.sv @@
// Shared types and constants for the receive frame parser.
// Used by every module of the core; depends on nothing.
package afp_pkg;

   // Byte values with a protocol meaning
   localparam logic [7:0] FRAME_DELIMITER = 8'h7E;
   localparam logic [7:0] CHECKSUM_BASE   = 8'hFF;

   // Byte positions within a frame; zero means hunting
   localparam int unsigned POS_WIDTH = 5;
   localparam logic [POS_WIDTH-1:0] POS_HUNT        = 5'd0;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH_HI   = 5'd1;
   localparam logic [POS_WIDTH-1:0] POS_TYPE        = 5'd3;
   localparam logic [POS_WIDTH-1:0] POS_LONG_LAST   = 5'd11;
   localparam logic [POS_WIDTH-1:0] POS_SHORT_LAST  = 5'd13;
   localparam logic [POS_WIDTH-1:0] POS_OPTIONS     = 5'd14;
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD     = 5'd15;
   localparam logic [POS_WIDTH-1:0] POS_CHECKSUM    = 5'd16;

   // Result beat layout
   localparam int unsigned RESULT_BITS = 105;
   localparam int unsigned RSP_WIDTH   = 112;

   // One received byte handed to the parser
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } afp_beat_type;

   // Fields of one parsed frame, last member in the lowest bits
   typedef struct packed {
      logic        checksum_ok;
      logic [7:0]  payload;
      logic [7:0]  option_bits;
      logic [15:0] network_address;
      logic [63:0] source_address;
      logic [7:0]  frame_type;
   } afp_result_type;

endpackage

@@ rtl/core/afp_input_stage.sv @@
// Input register for received bytes; releases a byte when the result side can take it.
// Depends on afp_pkg.
module afp_input_stage
   import afp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         downstream_ready,
   output afp_beat_type beat
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       take;

   // Release the held byte when the result register has room
   assign take       = valid_ff && downstream_ready;
   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) ? 1'b1 : (valid_ff && !take);

   assign beat.valid = take;
   assign beat.data  = data_ff;

   // Hold the control bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new byte on each accepted beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
      end
   end

endmodule

@@ rtl/core/afp_parser.sv @@
// Frame position tracker, field capture and running checksum.
// Depends on afp_pkg.
module afp_parser
   import afp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  afp_beat_type   beat,
   output logic           result_valid,
   output afp_result_type result
);

   logic [POS_WIDTH-1:0] pos_ff;
   logic [POS_WIDTH-1:0] pos_in;
   logic [7:0]           sum_ff;
   logic [7:0]           sum_in;
   logic [7:0]           type_ff;
   logic [63:0]          long_ff;
   logic [15:0]          short_ff;
   logic [7:0]           options_ff;
   logic [7:0]           payload_ff;
   logic                 hunting;
   logic                 covered;
   logic [7:0]           expected;

   assign hunting  = (pos_ff == POS_HUNT) || (pos_ff > POS_CHECKSUM);
   assign covered  = !hunting && (pos_ff >= POS_TYPE) && (pos_ff != POS_CHECKSUM);
   assign expected = CHECKSUM_BASE - sum_ff;

   // Advance the position and the running sum
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (beat.valid) begin
         if (hunting) begin
            if (beat.data == FRAME_DELIMITER) begin
               pos_in = POS_LENGTH_HI;
               sum_in = 8'd0;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_CHECKSUM) begin
            pos_in = POS_HUNT;
         end else begin
            pos_in = pos_ff + 5'd1;
            if (covered) begin
               sum_in = sum_ff + beat.data;
            end
         end
      end
   end

   // Hold position and sum
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Capture frame fields; every field is rewritten before it is shown
   always_ff @(posedge clock) begin
      if (beat.valid && covered) begin
         if (pos_ff == POS_TYPE) begin
            type_ff <= beat.data;
         end else if (pos_ff <= POS_LONG_LAST) begin
            long_ff <= {long_ff[55:0], beat.data};
         end else if (pos_ff <= POS_SHORT_LAST) begin
            short_ff <= {short_ff[7:0], beat.data};
         end else if (pos_ff == POS_OPTIONS) begin
            options_ff <= beat.data;
         end else if (pos_ff == POS_PAYLOAD) begin
            payload_ff <= beat.data;
         end
      end
   end

   // Emit the frame on its checksum byte
   assign result_valid           = beat.valid && (pos_ff == POS_CHECKSUM);
   assign result.frame_type      = type_ff;
   assign result.source_address  = long_ff;
   assign result.network_address = short_ff;
   assign result.option_bits     = options_ff;
   assign result.payload         = payload_ff;
   assign result.checksum_ok     = (beat.data == expected);

endmodule

@@ rtl/core/afp_output_stage.sv @@
// Result register driving the response stream.
// Depends on afp_pkg.
module afp_output_stage
   import afp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 result_valid,
   input  afp_result_type       result,
   output logic                 load_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_WIDTH-1:0] rsp_tdata
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [RSP_WIDTH-1:0] data_ff;

   // Room when empty or when the held beat leaves this cycle
   assign load_ready = !valid_ff || rsp_tready;
   assign valid_in   = result_valid ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the packed result, zero padding on top
   always_ff @(posedge clock) begin
      if (result_valid) begin
         data_ff <= {{(RSP_WIDTH - RESULT_BITS){1'b0}}, result};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

@@ rtl/core/api_receive_frame_parser_core.sv @@
// Receive frame parser for a serial API link: one byte in per beat, one frame result out.
// Accepts one byte every cycle while the result side has room; the checksum byte is held
// in the single-entry input register, then its result in the result register. Between
// frames the parser hunts for 0x7E, skips the two length bytes, captures type,
// 64-bit source address, 16-bit network address, options and one payload byte, and on
// the checksum byte emits all fields with checksum_ok set when the byte equals 0xFF
// minus the 8-bit sum of the captured bytes. A 0x7E inside a frame is plain data.
// Depends on afp_pkg, afp_input_stage, afp_parser and afp_output_stage.
module api_receive_frame_parser_core
   import afp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [7:0] frame_type, [71:8] source_address, [87:72] network_address,
   // [95:88] option_bits, [103:96] payload, [104] checksum_ok, [111:105] zero
   output logic [RSP_WIDTH-1:0] rsp_tdata
);

   afp_beat_type   beat;
   afp_result_type result;
   logic           result_valid;
   logic           load_ready;

   afp_input_stage u_input (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .downstream_ready (load_ready),
      .beat             (beat)
   );

   afp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .result_valid (result_valid),
      .result       (result)
   );

   afp_output_stage u_output (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .load_ready   (load_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

@@ rtl/core/afp_checker.sv @@
// Port-level checks for the receive frame parser, bound to the top level.
// Depends on afp_pkg and api_receive_frame_parser_core.
module afp_checker
   import afp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_WIDTH-1:0] rsp_tdata
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Keep taking bytes whenever the result side has room
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled with room on the result side");

   // A fresh result follows an accepted byte through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching checksum byte");

   // Padding above the result fields stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_WIDTH-1:RESULT_BITS] == '0))
      else $error("nonzero padding in result beat");

endmodule

bind api_receive_frame_parser_core afp_checker u_afp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/afp_frame_checker.sv @@
// Checker for the receive frame parser: watches both streams, predicts frames.
// Depends on afp_pkg for the position codes, protocol bytes and result layout.
`timescale 1ns / 100ps

module afp_frame_checker
   import afp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_WIDTH-1:0] rsp_tdata,
   output int                   error_count,
   output int                   pending_count
);

   // Frames predicted but not yet seen on the result stream
   afp_result_type frames_due[$];
   int             mismatches = 0;
   int             due_count  = 0;

   // Shadow copy of the parser state
   logic [POS_WIDTH-1:0] position;
   logic [7:0]           byte_sum;
   logic [7:0]           held_type;
   logic [63:0]          held_source;
   logic [15:0]          held_network;
   logic [7:0]           held_options;
   logic [7:0]           held_payload;

   assign error_count   = mismatches;
   assign pending_count = due_count;

   // Advance the shadow parser by one received byte
   task automatic track_byte(input logic [7:0] rx);
      afp_result_type frame;
      if (position == POS_HUNT || position > POS_CHECKSUM) begin
         if (rx == FRAME_DELIMITER) begin
            position = POS_LENGTH_HI;
            byte_sum = 8'd0;
         end else begin
            position = POS_HUNT;
         end
      end else if (position == POS_CHECKSUM) begin
         frame.frame_type      = held_type;
         frame.source_address  = held_source;
         frame.network_address = held_network;
         frame.option_bits     = held_options;
         frame.payload         = held_payload;
         frame.checksum_ok     = (rx == CHECKSUM_BASE - byte_sum);
         frames_due.push_back(frame);
         position = POS_HUNT;
      end else begin
         // Length bytes are skipped; everything from the type on is summed
         if (position >= POS_TYPE) begin
            byte_sum = byte_sum + rx;
            if (position == POS_TYPE) begin
               held_type = rx;
            end else if (position <= POS_LONG_LAST) begin
               held_source = {held_source[55:0], rx};
            end else if (position <= POS_SHORT_LAST) begin
               held_network = {held_network[7:0], rx};
            end else if (position == POS_OPTIONS) begin
               held_options = rx;
            end else begin
               held_payload = rx;
            end
         end
         position = position + 1'b1;
      end
   endtask

   // Compare one result beat against the oldest predicted frame
   task automatic check_frame(input afp_result_type got);
      afp_result_type want;
      if (frames_due.size() == 0) begin
         $error("unexpected result beat: %h", got);
         mismatches++;
      end else begin
         want = frames_due.pop_front();
         if (got.frame_type !== want.frame_type) begin
            $error("frame_type: expected %h, got %h", want.frame_type, got.frame_type);
            mismatches++;
         end
         if (got.source_address !== want.source_address) begin
            $error("source_address: expected %h, got %h",
                   want.source_address, got.source_address);
            mismatches++;
         end
         if (got.network_address !== want.network_address) begin
            $error("network_address: expected %h, got %h",
                   want.network_address, got.network_address);
            mismatches++;
         end
         if (got.option_bits !== want.option_bits) begin
            $error("option_bits: expected %h, got %h", want.option_bits, got.option_bits);
            mismatches++;
         end
         if (got.payload !== want.payload) begin
            $error("payload: expected %h, got %h", want.payload, got.payload);
            mismatches++;
         end
         if (got.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %b, got %b", want.checksum_ok, got.checksum_ok);
            mismatches++;
         end
      end
   endtask

   // Sample both streams at each edge; check results before predicting new ones
   always @(posedge clock) begin
      if (reset) begin
         position     = POS_HUNT;
         byte_sum     = 8'd0;
         held_type    = 8'd0;
         held_source  = 64'd0;
         held_network = 16'd0;
         held_options = 8'd0;
         held_payload = 8'd0;
         frames_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_frame(afp_result_type'(rsp_tdata[RESULT_BITS-1:0]));
         end
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata);
         end
      end
      due_count <= frames_due.size();
   end

endmodule

@@ sim/api_receive_frame_parser_core_test.sv @@
// Top of the receive frame parser testbench: clock, reset, byte stimulus, verdict.
// Depends on afp_pkg, the parser core and afp_frame_checker.
`timescale 1ns / 100ps

module api_receive_frame_parser_core_test
   import afp_pkg::*;
();

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'd0;   // [7:0] rx_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [7:0] frame_type, [71:8] source_address, [87:72] network_address,
   // [95:88] option_bits, [103:96] payload, [104] checksum_ok, [111:105] zero
   logic [RSP_WIDTH-1:0] rsp_tdata;

   int error_count;
   int pending_count;
   int bytes_sent  = 0;
   int frames_sent = 0;
   bit calm        = 1'b0;

   api_receive_frame_parser_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   afp_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Random idle cycle, suppressed during the calm stretch
   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < 18);
   endfunction

   // Field byte biased toward the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Stall the result stream at random
   always @(posedge clock) begin
      rsp_tready <= !take_gap();
   end

   // Present one byte and hold it until the beat is accepted
   task automatic send_byte(input logic [7:0] rx);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Send a whole frame; corrupt flips bits of the checksum byte
   task automatic send_frame(input logic [7:0] ftype, input logic [63:0] source,
                             input logic [15:0] network, input logic [7:0] options,
                             input logic [7:0] data, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] check;
      sum = ftype + options + data + network[15:8] + network[7:0];
      for (int i = 0; i < 8; i++) sum = sum + source[8*i +: 8];
      check = CHECKSUM_BASE - sum;
      if (corrupt) check = check ^ 8'($urandom_range(1, 255));
      send_byte(FRAME_DELIMITER);
      send_byte(pick_byte());
      send_byte(pick_byte());
      send_byte(ftype);
      for (int i = 7; i >= 0; i--) send_byte(source[8*i +: 8]);
      send_byte(network[15:8]);
      send_byte(network[7:0]);
      send_byte(options);
      send_byte(data);
      send_byte(check);
      frames_sent++;
   endtask

   // Hold off the sender until every predicted frame has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] source;
      int          pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: noise while hunting, delimiter as frame data, extremes, bad checksum
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7D);
      send_frame(FRAME_DELIMITER, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 8'hFF, 8'h00, 1'b0);
      send_frame(8'h00, 64'h0000_0000_0000_0000, 16'hFFFF, 8'h00, FRAME_DELIMITER, 1'b1);
      drain_results();

      // Random: mostly well-formed frames, some noise and truncated frames
      while (bytes_sent < 1700) begin
         calm = (bytes_sent >= 700) && (bytes_sent < 1000);
         pick = $urandom_range(9);
         if (pick < 8) begin
            for (int i = 0; i < 8; i++) source[8*i +: 8] = pick_byte();
            send_frame(pick_byte(), source, {pick_byte(), pick_byte()}, pick_byte(),
                       pick_byte(), $urandom_range(3) == 0);
            if (frames_sent % 25 == 0) drain_results();
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4)) send_byte(pick_byte());
         end else begin
            // Cut a frame short; the next frame's bytes become its data
            send_byte(FRAME_DELIMITER);
            repeat ($urandom_range(0, 15)) send_byte(pick_byte());
         end
      end
      calm = 1'b0;

      // Let the last results out, then give the verdict
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("api_receive_frame_parser_core_test: PASS");
      end else begin
         $display("api_receive_frame_parser_core_test: FAIL");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #2000000;
      $display("api_receive_frame_parser_core_test: FAIL");
      $finish;
   end

endmodule
